// ----- rtl/core/bitmap_block_allocator_top_macros.svh -----
// Assertion macros for the block allocator.
// Used by bitmap_block_allocator_top; expects aclk and aresetn in scope.
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bba_pkg.sv -----
// Shared constants for the bitmap block allocator.
// No dependencies; used by bitmap_block_allocator_top.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int BLOCK_CAP_DEF = 4096;
    localparam int WORD_BITS_DEF = 64;

    localparam int OP_W    = 2;
    localparam int BLK_W   = 12;
    localparam int COUNT_W = 13;
    localparam int IDX_W   = 2;

    localparam logic [OP_W-1:0] OP_FREE  = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;

    localparam logic [IDX_W-1:0] REG_TOTAL_BLOCKS = 2'd0;
    localparam logic [IDX_W-1:0] REG_FIRST_DATA   = 2'd1;
    localparam logic [IDX_W-1:0] REG_INIT_FREE    = 2'd2;

    localparam logic [COUNT_W-1:0] TOTAL_RESET     = 13'd4096;
    localparam logic [BLK_W-1:0]   FIRST_RESET     = 12'd0;
    localparam logic [COUNT_W-1:0] INIT_FREE_RESET = 13'd4096;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 13'h1FFF;

endpackage

// ----- rtl/core/bitmap_block_allocator_top.sv -----
// Bitmap block allocator: usage bitmap in one synchronous RAM, first-fit scan.
// Rejected ops skip the scan and go straight to the result; free/mark scan words
// from word 0 up to the one holding block b; allocate scans up to the last word in
// range. One item at a time: the next item is taken once the result is posted.
// Reset: synchronous; a clearing pass writes all MAP_WORDS words
// with s_tready low; configuration writes are taken throughout.
// Depends on bba_pkg and bitmap_block_allocator_top_macros.svh.
`timescale 1ns / 1ps

`include "bitmap_block_allocator_top_macros.svh"

module bitmap_block_allocator_top #(
    parameter int BLOCK_CAP = bba_pkg::BLOCK_CAP_DEF,
    parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bba_pkg::IDX_W-1:0]  cfg_index,
    input  logic [bba_pkg::COUNT_W-1:0] cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,   // [11:0] block_number, [15:12] zero
    input  logic [bba_pkg::OP_W-1:0]   s_tuser,   // [1:0] operation
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // [11:0] allocated_block, [24:12] free_count
    output logic [0:0]                 m_tuser    // [0] status
);

    localparam int MAP_WORDS = (BLOCK_CAP + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BASE_W    = $clog2((MAP_WORDS + 2) * WORD_BITS);
    localparam int CALC_W    = ((BASE_W > bba_pkg::COUNT_W) ? BASE_W : bba_pkg::COUNT_W) + 1;
    localparam int OFF_W     = $clog2(WORD_BITS + 1);
    localparam int POS_W     = $clog2(WORD_BITS);
    localparam int BLK_W     = bba_pkg::BLK_W;
    localparam int CNT_W     = bba_pkg::COUNT_W;

    localparam logic [AW-1:0]     LAST_ADDR = AW'(MAP_WORDS - 1);
    localparam logic [CALC_W-1:0] MAX_C     = CALC_W'(BLOCK_CAP);
    localparam logic [CALC_W-1:0] WB_C      = CALC_W'(WORD_BITS);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_POST  = 2'd3;

    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [1:0]        state_reg, state_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [AW-1:0]     issue_addr_reg, issue_addr_next;
    logic [BASE_W-1:0] issue_base_reg, issue_base_next;
    logic [AW-1:0]     chk_addr_reg, chk_addr_next;
    logic [BASE_W-1:0] chk_base_reg, chk_base_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [bba_pkg::OP_W-1:0] op_reg, op_next;
    logic [BLK_W-1:0]  blk_reg, blk_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [BLK_W-1:0]  first_reg, first_next;
    logic [CNT_W-1:0]  init_free_reg, init_free_next;
    logic [CNT_W-1:0]  free_cnt_reg, free_cnt_next;
    logic              res_status_reg, res_status_next;
    logic [BLK_W-1:0]  res_blk_reg, res_blk_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_status_reg, m_status_next;
    logic [BLK_W-1:0]  m_blk_reg, m_blk_next;
    logic [CNT_W-1:0]  m_cnt_reg, m_cnt_next;

    logic                 cfg_fire, s_fire, out_free;
    logic [CALC_W-1:0]    lim, base_c, blk_c, first_c;
    logic signed [CALC_W-1:0] lo_s, hi_s, diff_s;
    logic [OFF_W-1:0]     lo_c, hi_c;
    logic [WORD_BITS-1:0] mask, cand, bit_sel, wr_data;
    logic [POS_W-1:0]     found_pos, pos;
    logic                 found, hit, is_alloc, word_last;
    logic                 rd_en, wr_en;
    logic [AW-1:0]        wr_addr;
    logic [CNT_W-1:0]     cnt_up, cnt_down;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid & s_tready;
    assign out_free  = ~m_valid_reg | m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_cnt_reg, m_blk_reg};
    assign m_tuser  = m_status_reg;

    assign lim     = (CALC_W'(total_reg) < MAX_C) ? CALC_W'(total_reg) : MAX_C;
    assign base_c  = CALC_W'(chk_base_reg);
    assign blk_c   = CALC_W'(blk_reg);
    assign first_c = CALC_W'(first_reg);
    assign is_alloc = (op_reg == bba_pkg::OP_ALLOC);

    assign cnt_up   = (free_cnt_reg != bba_pkg::COUNT_MAX) ? free_cnt_reg + 1'b1 : free_cnt_reg;
    assign cnt_down = (free_cnt_reg != '0) ? free_cnt_reg - 1'b1 : free_cnt_reg;

    // window of eligible bits within the word under examination
    always_comb begin
        lo_s   = $signed(first_c - base_c);
        hi_s   = $signed(lim - base_c);
        diff_s = $signed(blk_c - base_c);
        if (lo_s < 0) begin
            lo_c = '0;
        end else if (lo_s > $signed(WB_C)) begin
            lo_c = OFF_W'(WORD_BITS);
        end else begin
            lo_c = lo_s[OFF_W-1:0];
        end
        if (hi_s < 0) begin
            hi_c = '0;
        end else if (hi_s > $signed(WB_C)) begin
            hi_c = OFF_W'(WORD_BITS);
        end else begin
            hi_c = hi_s[OFF_W-1:0];
        end
        for (int j = 0; j < WORD_BITS; j++) begin
            mask[j] = (OFF_W'(j) >= lo_c) && (OFF_W'(j) < hi_c);
        end
        cand = ~rd_data_reg & mask;
    end

    // find first zero
    always_comb begin
        found_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (cand[j]) begin
                found_pos = POS_W'(j);
            end
        end
        found     = |cand;
        hit       = (diff_s >= 0) && (diff_s < $signed(WB_C));
        word_last = (base_c + WB_C) >= lim;
        pos       = is_alloc ? found_pos : diff_s[POS_W-1:0];
        bit_sel   = WORD_BITS'(1) << pos;
        wr_data   = (op_reg == bba_pkg::OP_FREE) ? (rd_data_reg & ~bit_sel)
                                                 : (rd_data_reg | bit_sel);
    end

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        issue_addr_next = issue_addr_reg;
        issue_base_next = issue_base_reg;
        chk_addr_next   = chk_addr_reg;
        chk_base_next   = chk_base_reg;
        chk_valid_next  = 1'b0;
        op_next         = op_reg;
        blk_next        = blk_reg;
        total_next      = total_reg;
        first_next      = first_reg;
        init_free_next  = init_free_reg;
        free_cnt_next   = free_cnt_reg;
        res_status_next = res_status_reg;
        res_blk_next    = res_blk_reg;
        m_valid_next    = m_valid_reg & ~m_tready;
        m_status_next   = m_status_reg;
        m_blk_next      = m_blk_reg;
        m_cnt_next      = m_cnt_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = chk_addr_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    op_next         = s_tuser;
                    blk_next        = s_tdata[BLK_W-1:0];
                    issue_addr_next = '0;
                    issue_base_next = '0;
                    res_status_next = 1'b1;
                    res_blk_next    = '0;
                    if ((s_tuser == bba_pkg::OP_ALLOC) ||
                        (((s_tuser == bba_pkg::OP_FREE) || (s_tuser == bba_pkg::OP_MARK)) &&
                         (CALC_W'(s_tdata[BLK_W-1:0]) < lim))) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_POST;
                    end
                end
            end
            ST_SCAN: begin
                rd_en           = 1'b1;
                chk_valid_next  = 1'b1;
                chk_addr_next   = issue_addr_reg;
                chk_base_next   = issue_base_reg;
                issue_base_next = issue_base_reg + BASE_W'(WORD_BITS);
                if (issue_addr_reg != LAST_ADDR) begin
                    issue_addr_next = issue_addr_reg + 1'b1;
                end
                if (chk_valid_reg) begin
                    if (is_alloc ? found : hit) begin
                        wr_en           = 1'b1;
                        free_cnt_next   = (op_reg == bba_pkg::OP_FREE) ? cnt_up : cnt_down;
                        res_status_next = 1'b0;
                        res_blk_next    = is_alloc ? BLK_W'(chk_base_reg + BASE_W'(found_pos))
                                                   : '0;
                        chk_valid_next  = 1'b0;
                        state_next      = ST_POST;
                    end else if (is_alloc && word_last) begin
                        chk_valid_next  = 1'b0;
                        state_next      = ST_POST;
                    end
                end
            end
            ST_POST: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_blk_next    = res_blk_reg;
                    m_cnt_next    = free_cnt_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_fire) begin
            unique case (cfg_index)
                bba_pkg::REG_TOTAL_BLOCKS: total_next = cfg_data;
                bba_pkg::REG_FIRST_DATA:   first_next = cfg_data[BLK_W-1:0];
                bba_pkg::REG_INIT_FREE: begin
                    init_free_next = cfg_data;
                    free_cnt_next  = cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            chk_valid_reg <= 1'b0;
            total_reg     <= bba_pkg::TOTAL_RESET;
            first_reg     <= bba_pkg::FIRST_RESET;
            init_free_reg <= bba_pkg::INIT_FREE_RESET;
            free_cnt_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            chk_valid_reg <= chk_valid_next;
            total_reg     <= total_next;
            first_reg     <= first_next;
            init_free_reg <= init_free_next;
            free_cnt_reg  <= free_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_addr_reg <= issue_addr_next;
        issue_base_reg <= issue_base_next;
        chk_addr_reg   <= chk_addr_next;
        chk_base_reg   <= chk_base_next;
        op_reg         <= op_next;
        blk_reg        <= blk_next;
        res_status_reg <= res_status_next;
        res_blk_reg    <= res_blk_next;
        m_status_reg   <= m_status_next;
        m_blk_reg      <= m_blk_next;
        m_cnt_reg      <= m_cnt_next;
    end

    // bitmap RAM, registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[issue_addr_reg];
        end
        if (wr_en) begin
            mem[wr_addr] <= (state_reg == ST_CLEAR) ? '0 : wr_data;
        end
    end

    `BBA_ASSERT_NOW(a_no_write_idle, (state_reg == ST_IDLE) || (state_reg == ST_POST), !wr_en, "bitmap written outside scan or clear")
    `BBA_ASSERT_NEXT(a_write_ends_scan, wr_en && (state_reg == ST_SCAN), state_reg == ST_POST, "scan continued after update")
    `BBA_ASSERT_NEXT(a_fail_keeps_count, (state_reg == ST_SCAN) && chk_valid_reg && is_alloc && !found && word_last && !cfg_fire, $stable(free_cnt_reg), "failed allocate changed counter")

endmodule
